>>> rtl/reol_pkg.sv
// Package for the ring entry offset locator: word layouts, field widths,
// operation codes, sequencer states and the control and status structs.
// No dependencies.
package reol_pkg;

   localparam int HANDLE_W    = 32;
   localparam int SIZE_W      = 16;
   localparam int OFFS_W      = 20;
   localparam int SLOT_W      = 4;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_FIELD_W = 106;
   localparam int RSP_TDATA_W = 112;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_FIND = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVICT,
      S_FIND,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   size;
   } slot_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   size;
      logic [OFFS_W-1:0]   offs;
   } item_type;

   typedef struct packed {
      logic [OFFS_W-1:0]   total_bytes;
      logic [HANDLE_W-1:0] evicted_handle;
      logic                evicted;
      logic [SIZE_W-1:0]   byte_offset;
      logic [HANDLE_W-1:0] hit_handle;
      logic [SLOT_W-1:0]   hit_slot;
      logic                found;
   } result_type;

   typedef struct packed {
      logic start;
      logic step;
   } walk_ctrl_type;

   typedef struct packed {
      logic hit;
      logic last;
   } walk_stat_type;

endpackage

>>> rtl/reol_ring_mem.sv
// Slot storage for the ring: one write port and one registered read port.
// Uses reol_pkg for the slot layout.
module reol_ring_mem
   import reol_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  slot_type          wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output slot_type          rd_data
);

   slot_type mem_ff [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/reol_walk.sv
// Compare and subtract unit; walks stored slots one per cycle while stepped.
// Holds the remaining offset, slot index and slot count; uses reol_pkg.
module reol_walk
   import reol_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int PTR_W = 4,
   parameter int CNT_W = 5
) (
   input  logic              clock,
   input  walk_ctrl_type     ctrl,
   input  logic [OFFS_W-1:0] start_offs,
   input  logic [PTR_W-1:0]  start_idx,
   input  logic [CNT_W-1:0]  start_cnt,
   input  logic [SIZE_W-1:0] rd_size,
   output walk_stat_type     stat,
   output logic [PTR_W-1:0]  idx,
   output logic [PTR_W-1:0]  idx_next,
   output logic [SIZE_W-1:0] offs_low
);

   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

   logic [OFFS_W-1:0] offs_ff, offs_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [OFFS_W-1:0] size_ext;

   assign size_ext = {{(OFFS_W - SIZE_W){1'b0}}, rd_size};
   assign idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;

   always_comb begin
      offs_in = offs_ff;
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      if (ctrl.start) begin
         offs_in = start_offs;
         idx_in  = start_idx;
         cnt_in  = start_cnt;
      end else if (ctrl.step) begin
         offs_in = offs_ff - size_ext;
         idx_in  = idx_next;
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      offs_ff <= offs_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
   end

   assign stat.hit  = offs_ff < size_ext;
   assign stat.last = cnt_ff == CNT_W'(1);
   assign idx       = idx_ff;
   assign offs_low  = offs_ff[SIZE_W-1:0];

endmodule

>>> rtl/ring_entry_offset_locator.sv
// Top level of the ring entry offset locator: sequencer, pointers, byte total
// and output register. Depends on reol_pkg, reol_ring_mem and reol_walk.
//
//   channel | ports                      | word
//   request | req_tvalid/tready/tdata/tuser | add or find item
//   result  | rsp_tvalid/tready/tdata    | one result word per item
//
// An add into a ring with room writes the slot and emits. An add into a full
// ring passes through S_EVICT, which takes the evicted slot from the read port.
// A find walks one stored slot per cycle, set by the single slot store read port.
// Reset clears pointers, fill flag, byte total and the sequencer; slot data
// is not cleared. A stalled result holds in the output register while the
// next item is taken; that item waits to emit until the register frees.
module ring_entry_offset_locator
   import reol_pkg::*;
#(
   parameter int RING_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // entry_handle[31:0], entry_size[47:32], char_pos[67:48], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // operation[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // found[0], hit_slot[4:1], hit_handle[36:5], byte_offset[52:37], evicted[53],
   // evicted_handle[85:54], total_bytes[105:86], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  write_ptr_ff, write_ptr_in;
   logic [PTR_W-1:0]  read_ptr_ff, read_ptr_in;
   logic              ring_full_ff, ring_full_in;
   logic [OFFS_W-1:0] byte_total_ff, byte_total_in;
   item_type          item_ff, item_in;
   result_type        res_ff, res_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   result_type        rsp_res_ff, rsp_res_in;

   logic              mem_we;
   slot_type          mem_wdata;
   logic [PTR_W-1:0]  mem_raddr;
   slot_type          mem_rdata;

   walk_ctrl_type     walk_ctrl;
   walk_stat_type     walk_stat;
   logic [PTR_W-1:0]  walk_idx;
   logic [PTR_W-1:0]  walk_idx_next;
   logic [SIZE_W-1:0] walk_offs;
   logic [CNT_W-1:0]  stored_cnt;
   item_type          req_item;

   assign req_item.handle = req_tdata[31:0];
   assign req_item.size   = req_tdata[47:32];
   assign req_item.offs   = req_tdata[67:48];

   always_comb begin
      if (ring_full_ff) begin
         stored_cnt = FULL_CNT;
      end else if (write_ptr_ff >= read_ptr_ff) begin
         stored_cnt = CNT_W'(write_ptr_ff) - CNT_W'(read_ptr_ff);
      end else begin
         stored_cnt = CNT_W'(write_ptr_ff) + FULL_CNT - CNT_W'(read_ptr_ff);
      end
   end

   reol_ring_mem #(
      .DEPTH  (RING_DEPTH),
      .ADDR_W (PTR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (write_ptr_ff),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   reol_walk #(
      .DEPTH (RING_DEPTH),
      .PTR_W (PTR_W),
      .CNT_W (CNT_W)
   ) u_walk (
      .clock      (clock),
      .ctrl       (walk_ctrl),
      .start_offs (req_item.offs),
      .start_idx  (read_ptr_ff),
      .start_cnt  (stored_cnt),
      .rd_size    (mem_rdata.size),
      .stat       (walk_stat),
      .idx        (walk_idx),
      .idx_next   (walk_idx_next),
      .offs_low   (walk_offs)
   );

   always_comb begin
      state_in         = state_ff;
      write_ptr_in     = write_ptr_ff;
      read_ptr_in      = read_ptr_ff;
      ring_full_in     = ring_full_ff;
      byte_total_in    = byte_total_ff;
      item_in          = item_ff;
      res_in           = res_ff;
      rsp_tvalid_in    = rsp_tvalid_ff;
      rsp_res_in       = rsp_res_ff;
      mem_we           = 1'b0;
      mem_wdata.handle = item_ff.handle;
      mem_wdata.size   = item_ff.size;
      mem_raddr        = walk_idx_next;
      walk_ctrl        = '0;
      req_tready       = 1'b0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            mem_raddr  = read_ptr_ff;
            if (req_tvalid) begin
               item_in = req_item;
               res_in  = '0;
               res_in.total_bytes = byte_total_ff;
               if (op_type'(req_tuser) == OP_ADD) begin
                  if (ring_full_ff) begin
                     state_in = S_EVICT;
                  end else begin
                     mem_we           = 1'b1;
                     mem_wdata.handle = req_item.handle;
                     mem_wdata.size   = req_item.size;
                     write_ptr_in     = ptr_next(write_ptr_ff);
                     ring_full_in     = ptr_next(write_ptr_ff) == read_ptr_ff;
                     byte_total_in    = byte_total_ff
                                      + {{(OFFS_W - SIZE_W){1'b0}}, req_item.size};
                     res_in.total_bytes = byte_total_in;
                     state_in = S_EMIT;
                  end
               end else if (stored_cnt == '0) begin
                  state_in = S_EMIT;
               end else begin
                  walk_ctrl.start = 1'b1;
                  state_in = S_FIND;
               end
            end
         end
         S_EVICT: begin
            mem_we        = 1'b1;
            read_ptr_in   = ptr_next(read_ptr_ff);
            write_ptr_in  = ptr_next(write_ptr_ff);
            byte_total_in = byte_total_ff
                          - {{(OFFS_W - SIZE_W){1'b0}}, mem_rdata.size}
                          + {{(OFFS_W - SIZE_W){1'b0}}, item_ff.size};
            res_in.evicted        = 1'b1;
            res_in.evicted_handle = mem_rdata.handle;
            res_in.total_bytes    = byte_total_in;
            state_in = S_EMIT;
         end
         S_FIND: begin
            if (walk_stat.hit) begin
               res_in.found       = 1'b1;
               res_in.hit_slot    = SLOT_W'(walk_idx);
               res_in.hit_handle  = mem_rdata.handle;
               res_in.byte_offset = walk_offs;
               state_in = S_EMIT;
            end else if (walk_stat.last) begin
               state_in = S_EMIT;
            end else begin
               walk_ctrl.step = 1'b1;
            end
         end
         S_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_res_in    = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         write_ptr_ff  <= '0;
         read_ptr_ff   <= '0;
         ring_full_ff  <= 1'b0;
         byte_total_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_ptr_ff  <= write_ptr_in;
         read_ptr_ff   <= read_ptr_in;
         ring_full_ff  <= ring_full_in;
         byte_total_ff <= byte_total_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      res_ff     <= res_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}}, rsp_res_ff};

   a_full_ptrs_equal: assert property (@(posedge clock) disable iff (reset)
      ring_full_ff |-> write_ptr_ff == read_ptr_ff)
      else $error("ring full with pointers apart");

   a_evict_needs_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVICT |-> ring_full_ff)
      else $error("eviction from a ring that is not full");

   a_find_keeps_total: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIND |=> $stable(byte_total_ff) && $stable(write_ptr_ff))
      else $error("find changed ring state");

   a_ptrs_in_range: assert property (@(posedge clock) disable iff (reset)
      write_ptr_ff <= LAST_IDX && read_ptr_ff <= LAST_IDX)
      else $error("ring pointer out of range");

endmodule
